[hdl/ufdr_pkg.sv]
// shared types, constants and helper functions of the frame decoder and router
package ufdr_pkg;

    localparam int MAX_PAYLOAD  = 32;
    localparam int HEADER_BYTES = 8;
    localparam int HDR_COUNT    = HEADER_BYTES - 2;
    localparam int HDR_AW       = $clog2(HDR_COUNT);
    localparam int PL_AW        = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int RAM_AW       = PL_AW + 1;
    localparam int RAM_DEPTH    = 2 ** RAM_AW;
    localparam int PLEN_W       = 6;
    localparam int POS_W        = 9;
    localparam int CFG_AW       = 5;
    localparam int QDEPTH       = 2;

    localparam logic [7:0]  BOOT_LEN = 8'd4;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [3:0] ST_LOCAL     = 4'd0;
    localparam logic [3:0] ST_FORWARD   = 4'd1;
    localparam logic [3:0] ST_BROADCAST = 4'd2;
    localparam logic [3:0] ST_BOOT      = 4'd3;
    localparam logic [3:0] ST_CRC_ERR   = 4'd4;
    localparam logic [3:0] ST_VER_ERR   = 4'd5;
    localparam logic [3:0] ST_DEST_ERR  = 4'd6;
    localparam logic [3:0] ST_UNROUTED  = 4'd7;
    localparam logic [3:0] ST_LEN_ERR   = 4'd8;

    localparam logic [2:0] REG_VERSION   = 3'd0;
    localparam logic [2:0] REG_PC_ID     = 3'd1;
    localparam logic [2:0] REG_BOOT_ID   = 3'd2;
    localparam logic [2:0] REG_LOCAL_ID  = 3'd3;
    localparam logic [2:0] REG_DRONE_ID  = 3'd4;
    localparam logic [2:0] REG_BCAST_ID  = 3'd5;

    typedef struct packed {
        logic [7:0] version;
        logic [7:0] pc_id;
        logic [7:0] boot_id;
        logic [7:0] local_id;
        logic [7:0] drone_id;
        logic [7:0] bcast_id;
    } t_cfg;

    // one finished frame, handed from front to back
    typedef struct packed {
        logic [3:0]        status;
        logic [7:0]        version;
        logic [7:0]        flags;
        logic [7:0]        src;
        logic [7:0]        dest;
        logic [7:0]        opcode;
        logic [PLEN_W-1:0] plen;
        logic [7:0]        boot_addr;
        logic [7:0]        boot_cmd;
        logic              bank;
        logic              drain;
    } t_desc;

    // back is done with a payload bank
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
        logic [15:0] c;
        c = c_in ^ {8'h00, d};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [3:0] route(input logic [7:0] dest, input t_cfg cfg);
        logic [3:0] st;
        if (dest == cfg.pc_id) begin
            st = ST_DEST_ERR;
        end else if (dest == cfg.boot_id) begin
            st = ST_DEST_ERR;
        end else if (dest == cfg.local_id) begin
            st = ST_LOCAL;
        end else if (dest == cfg.drone_id) begin
            st = ST_FORWARD;
        end else if (dest == cfg.bcast_id) begin
            st = ST_BROADCAST;
        end else begin
            st = ST_UNROUTED;
        end
        return st;
    endfunction

endpackage

[hdl/uart_frame_decoder_router_top.sv]
// top level of the frame decoder and router with its configuration registers
//
// input channel (i_valid / o_ready) takes one frame byte per item; i_frame_start
// marks byte 0 of a frame, byte 1 is the length, the crc follows the body.
// output channel (o_valid / i_ready) gives one status item per ended frame and,
// for frames routed to the remote node, one item per payload byte after it.
// the front accepts one byte per cycle while o_ready is high; a frame's status
// item passes the queue, the back and the output register after its final crc
// byte is accepted; payload items follow at one per cycle while i_ready is high.
// payload is kept in two ram banks, one per outstanding frame; the front holds
// o_ready low only when both banks still wait for the back to emit their frames.
// when the receiver stalls, the output register holds its item, the back waits,
// and the front keeps taking bytes until both banks are occupied.
// reset (synchronous, active low) clears the frame tracking, queue and output
// valid, and loads the register defaults; the ram needs no clearing.
// registers sit on the apb-style port at byte address 4*index and may be
// written only while the block is idle.
module uart_frame_decoder_router_top import ufdr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_frame_start,
    // result output
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3:0]        o_status,
    output logic [7:0]        o_version_byte,
    output logic [7:0]        o_flag_bits,
    output logic [7:0]        o_source_id,
    output logic [7:0]        o_dest_id,
    output logic [7:0]        o_op_code,
    output logic [5:0]        o_payload_length,
    output logic [7:0]        o_boot_address,
    output logic [7:0]        o_boot_command,
    output logic [7:0]        o_payload_byte,
    output logic              o_payload_valid,
    output logic              o_last,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg              r_cfg;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    logic              push;
    t_desc             push_desc;
    logic              pop;
    logic              q_empty;
    t_desc             q_head;
    t_release          release_bank;
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [RAM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    // register file: written in the apb access phase, never waits
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.version  <= 8'd1;
            r_cfg.pc_id    <= 8'd0;
            r_cfg.boot_id  <= 8'd1;
            r_cfg.local_id <= 8'd2;
            r_cfg.drone_id <= 8'd3;
            r_cfg.bcast_id <= 8'd255;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_VERSION:  r_cfg.version  <= pwdata[7:0];
                REG_PC_ID:    r_cfg.pc_id    <= pwdata[7:0];
                REG_BOOT_ID:  r_cfg.boot_id  <= pwdata[7:0];
                REG_LOCAL_ID: r_cfg.local_id <= pwdata[7:0];
                REG_DRONE_ID: r_cfg.drone_id <= pwdata[7:0];
                REG_BCAST_ID: r_cfg.bcast_id <= pwdata[7:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // read back, addresses past the list read as zero
    always_comb begin
        case (cfg_idx)
            REG_VERSION:  prdata = {24'd0, r_cfg.version};
            REG_PC_ID:    prdata = {24'd0, r_cfg.pc_id};
            REG_BOOT_ID:  prdata = {24'd0, r_cfg.boot_id};
            REG_LOCAL_ID: prdata = {24'd0, r_cfg.local_id};
            REG_DRONE_ID: prdata = {24'd0, r_cfg.drone_id};
            REG_BCAST_ID: prdata = {24'd0, r_cfg.bcast_id};
            default:      prdata = 32'd0;
        endcase
    end

    // front: byte tracking, crc, header capture, classification
    ufdr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_cfg         (r_cfg),
        .i_release     (release_bank),
        .o_push        (push),
        .o_desc        (push_desc),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    // payload store, two banks addressed by the top address bit
    ufdr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // finished frames wait here; bank ownership keeps it from overflowing
    ufdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // back: status item then payload drain into the output register
    ufdr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (q_empty),
        .i_head           (q_head),
        .o_pop            (pop),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data),
        .o_release        (release_bank),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_version_byte   (o_version_byte),
        .o_flag_bits      (o_flag_bits),
        .o_source_id      (o_source_id),
        .o_dest_id        (o_dest_id),
        .o_op_code        (o_op_code),
        .o_payload_length (o_payload_length),
        .o_boot_address   (o_boot_address),
        .o_boot_command   (o_boot_command),
        .o_payload_byte   (o_payload_byte),
        .o_payload_valid  (o_payload_valid),
        .o_last           (o_last)
    );

endmodule

[hdl/ufdr_ram.sv]
// generic single-write, single-read ram with registered read data
module ufdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/ufdr_front.sv]
// front end: frame byte tracking, crc, header capture, payload write and classification
module ufdr_front import ufdr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_frame_start,
    input  t_cfg              i_cfg,
    input  t_release          i_release,
    output logic              o_push,
    output t_desc             o_desc,
    output logic              o_wr_en,
    output logic [RAM_AW-1:0] o_wr_addr,
    output logic [7:0]        o_wr_data
);

    logic             r_in_frame, n_in_frame;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_len, n_len;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_rcrc_lo, n_rcrc_lo;
    logic [7:0]       r_hdr [HDR_COUNT];
    logic [7:0]       n_hdr [HDR_COUNT];
    logic             r_wbank;
    logic [1:0]       r_busy;

    logic             acc;
    logic             fin;
    logic [POS_W-1:0] pos1;
    logic [POS_W-1:0] pidx;
    logic [HDR_AW-1:0] hidx;
    logic [7:0]       fin_len;
    logic             crc_ok;
    logic             len_bad;
    logic [7:0]       plen8;
    t_desc            desc;

    assign acc     = i_valid & o_ready;
    assign o_ready = ~r_busy[r_wbank];
    assign pos1    = r_pos + POS_W'(1);
    assign pidx    = pos1 - POS_W'(HEADER_BYTES);
    assign hidx    = HDR_AW'(pos1 - POS_W'(2));

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_len      = r_len;
        n_crc      = r_crc;
        n_rcrc_lo  = r_rcrc_lo;
        n_hdr      = r_hdr;
        fin        = 1'b0;
        o_wr_en    = 1'b0;
        if (acc) begin
            if (i_frame_start) begin
                n_in_frame = 1'b1;
                n_pos      = '0;
                n_len      = '0;
                n_crc      = CRC_INIT;
                n_rcrc_lo  = '0;
                for (int i = 0; i < HDR_COUNT; i++) begin
                    n_hdr[i] = '0;
                end
            end else if (r_in_frame) begin
                n_pos = pos1;
                if (pos1 == POS_W'(1)) begin
                    n_len = i_data_byte;
                    if (i_data_byte >= 8'd2) begin
                        n_crc = crc_byte(r_crc, i_data_byte);
                    end
                    if (i_data_byte == 8'd0) begin
                        fin = 1'b1;
                    end
                end else if (pos1 < POS_W'(r_len)) begin
                    n_crc = crc_byte(r_crc, i_data_byte);
                    if (pos1 < POS_W'(HEADER_BYTES)) begin
                        n_hdr[hidx] = i_data_byte;
                    end else if (pidx < POS_W'(MAX_PAYLOAD)) begin
                        o_wr_en = 1'b1;
                    end
                end else if (pos1 == POS_W'(r_len)) begin
                    n_rcrc_lo = i_data_byte;
                end else begin
                    fin = 1'b1;
                end
            end
            if (fin) begin
                n_in_frame = 1'b0;
            end
        end
    end

    assign o_wr_addr = {r_wbank, pidx[PL_AW-1:0]};
    assign o_wr_data = i_data_byte;

    // classification of the frame that ends with this byte
    assign fin_len = (r_pos == '0) ? 8'd0 : r_len;
    assign crc_ok  = (r_crc == {i_data_byte, r_rcrc_lo});
    assign plen8   = r_hdr[5];
    assign len_bad = (fin_len < 8'(HEADER_BYTES)) || (plen8 > 8'(MAX_PAYLOAD)) ||
                     ({1'b0, fin_len} != (9'(HEADER_BYTES) + {1'b0, plen8}));

    always_comb begin
        desc      = '0;
        desc.bank = r_wbank;
        if (fin_len == BOOT_LEN) begin
            desc.boot_addr = r_hdr[0];
            desc.boot_cmd  = r_hdr[1];
            if (!crc_ok) begin
                desc.status = ST_CRC_ERR;
            end else if (r_hdr[0] == i_cfg.boot_id) begin
                desc.status = ST_BOOT;
            end else if (i_cfg.version != 8'd0) begin
                desc.status = ST_VER_ERR;
            end else begin
                desc.status = route(8'd0, i_cfg);
            end
        end else if (len_bad) begin
            desc.status = ST_LEN_ERR;
        end else begin
            desc.version = r_hdr[0];
            desc.flags   = r_hdr[1];
            desc.src     = r_hdr[2];
            desc.dest    = r_hdr[3];
            desc.opcode  = r_hdr[4];
            desc.plen    = PLEN_W'(plen8);
            if (!crc_ok) begin
                desc.status = ST_CRC_ERR;
            end else if (r_hdr[0] != i_cfg.version) begin
                desc.status = ST_VER_ERR;
            end else begin
                desc.status = route(r_hdr[3], i_cfg);
            end
            desc.drain = (desc.status == ST_FORWARD) && (plen8 != 8'd0);
        end
    end

    assign o_push = fin;
    assign o_desc = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_len      <= '0;
            r_crc      <= CRC_INIT;
            r_rcrc_lo  <= '0;
            r_wbank    <= 1'b0;
            r_busy     <= '0;
            for (int i = 0; i < HDR_COUNT; i++) begin
                r_hdr[i] <= '0;
            end
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_crc      <= n_crc;
            r_rcrc_lo  <= n_rcrc_lo;
            r_hdr      <= n_hdr;
            if (fin) begin
                r_wbank          <= ~r_wbank;
                r_busy[r_wbank]  <= 1'b1;
            end
            if (i_release.valid) begin
                r_busy[i_release.bank] <= 1'b0;
            end
        end
    end

endmodule

[hdl/ufdr_queue.sv]
// two-entry queue of finished frame descriptors between front and back
module ufdr_queue import ufdr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output logic  o_empty,
    output t_desc o_head
);

    t_desc      r_q [QDEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hdl/ufdr_back.sv]
// back end: emits the status item and drains forwarded payload through the output register
module ufdr_back import ufdr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_desc             i_head,
    output logic              o_pop,
    output logic [RAM_AW-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data,
    output t_release          o_release,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3:0]        o_status,
    output logic [7:0]        o_version_byte,
    output logic [7:0]        o_flag_bits,
    output logic [7:0]        o_source_id,
    output logic [7:0]        o_dest_id,
    output logic [7:0]        o_op_code,
    output logic [5:0]        o_payload_length,
    output logic [7:0]        o_boot_address,
    output logic [7:0]        o_boot_command,
    output logic [7:0]        o_payload_byte,
    output logic              o_payload_valid,
    output logic              o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STAT = 2'd1;
    localparam logic [1:0] S_PAY  = 2'd2;

    logic [1:0]       r_state, n_state;
    t_desc            r_desc, n_desc;
    logic [PL_AW-1:0] r_idx, n_idx;
    logic             r_ov, n_ov;

    logic             slot_free;
    logic             load;
    logic             load_pay;
    logic             load_last;
    logic             pay_last;

    assign slot_free = ~r_ov | i_ready;
    assign pay_last  = (PLEN_W'(r_idx) == (r_desc.plen - PLEN_W'(1)));

    always_comb begin
        n_state   = r_state;
        n_desc    = r_desc;
        n_idx     = r_idx;
        n_ov      = r_ov & ~i_ready;
        o_pop     = 1'b0;
        load      = 1'b0;
        load_pay  = 1'b0;
        load_last = 1'b0;
        o_release = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_desc  = i_head;
                    n_idx   = '0;
                    n_state = S_STAT;
                end
            end
            S_STAT: begin
                if (slot_free) begin
                    load = 1'b1;
                    n_ov = 1'b1;
                    if (r_desc.drain) begin
                        n_state = S_PAY;
                    end else begin
                        load_last = 1'b1;
                        n_state   = S_IDLE;
                        o_release = '{valid: 1'b1, bank: r_desc.bank};
                    end
                end
            end
            S_PAY: begin
                if (slot_free) begin
                    load     = 1'b1;
                    load_pay = 1'b1;
                    n_ov     = 1'b1;
                    if (pay_last) begin
                        load_last = 1'b1;
                        n_state   = S_IDLE;
                        o_release = '{valid: 1'b1, bank: r_desc.bank};
                    end else begin
                        n_idx = r_idx + PL_AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // address the next index so read data lines up with r_idx
    assign o_rd_addr = {n_desc.bank, n_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        r_idx  <= n_idx;
        if (load) begin
            o_status         <= r_desc.status;
            o_version_byte   <= r_desc.version;
            o_flag_bits      <= r_desc.flags;
            o_source_id      <= r_desc.src;
            o_dest_id        <= r_desc.dest;
            o_op_code        <= r_desc.opcode;
            o_payload_length <= r_desc.plen;
            o_boot_address   <= r_desc.boot_addr;
            o_boot_command   <= r_desc.boot_cmd;
            o_payload_byte   <= load_pay ? i_rd_data : 8'd0;
            o_payload_valid  <= load_pay;
            o_last           <= load_last;
        end
    end

    assign o_valid = r_ov;

endmodule
